/* design/hrp_pkg.sv */
// Shared types and constants for the H.264 RTP payload packetizer.
package hrp_pkg;

  localparam int unsigned SizeBitsDefault = 24;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned MaxEvents       = 6;

  localparam logic [15:0] MtuReset   = 16'd1400;
  localparam logic [6:0]  PtReset    = 7'd96;

  localparam logic [1:0] CfgMtu = 2'd0;
  localparam logic [1:0] CfgAgg = 2'd1;
  localparam logic [1:0] CfgPt  = 2'd2;

  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;

  localparam logic [7:0] TypeMask = 8'h1F;
  localparam logic [7:0] NriMask  = 8'hE0;
  localparam logic [7:0] StapType = 8'd24;
  localparam logic [7:0] FuType   = 8'd28;
  localparam logic [7:0] FuStart  = 8'h80;
  localparam logic [7:0] FuEnd    = 8'h40;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        marker;
    logic [15:0] sequence_res;
    logic [31:0] timestamp_out;
    logic [6:0]  payload_type_out;
    logic        disposable;
    logic        last;
  } res_t;

  // One planned event inside a job; sequence and fields filled at issue.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_val;
    logic       flag;   // marker on end, unused otherwise
    logic       disp;
  } evt_t;

  // Work for the back end: up to six events from one input word.
  typedef struct packed {
    evt_t [MaxEvents-1:0] evt;
    logic [2:0]           count;
    logic [31:0]          ts;
    logic [6:0]           pt;
  } job_t;

endpackage

/* design/hrp_stream_if.sv */
// Valid/ready channel interface carrying one payload word.
interface hrp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/hrp_front.sv */
// Front end: decodes each input word against the packing state into a job.
module hrp_front import hrp_pkg::*; #(
  parameter int unsigned SizeBits = SizeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [7:0]          data_byte_i,
  input  logic                nal_first_i,
  input  logic [SizeBits-1:0] nal_size_i,
  input  logic                au_end_i,
  input  logic                au_start_i,
  input  logic [31:0]         timestamp_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output job_t                job_o
);

  localparam int unsigned WB = SizeBits + 2;

  logic [15:0]         mtu_q;
  logic                agg_q;
  logic [6:0]          pt_q;
  logic [15:0]         pb_q, pb_d;
  logic [SizeBits-1:0] rem_q, rem_d;
  logic [15:0]         fl_q, fl_d;
  logic [7:0]          hdr_q, hdr_d;
  logic                frag_q, frag_d, ff_q, ff_d, aue_q, aue_d, nro_q, nro_d;
  logic [31:0]         ts_q, ts_d;

  job_t       job;
  logic       fire;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign fire        = in_valid_i && job_ready_i;
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MtuReset;
      agg_q <= 1'b1;
      pt_q  <= PtReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMtu:  mtu_q <= cfg_data_i[15:0];
        CfgAgg:  agg_q <= cfg_data_i[0];
        CfgPt:   pt_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [SizeBits-1:0] size;
    logic [WB-1:0]       sum;
    logic                fits, fl_bad, nr;
    logic [1:0]          fl_code;
    logic [4:0]          t;
    logic [WB-1:0]       pbw;
    logic                do_frag;
    logic [15:0]         cap;
    logic [SizeBits-1:0] left;
    logic [15:0]         fsz;
    logic [7:0]          fu;
    logic [2:0]          n;

    job = '0;
    job.ts = ts_q;
    job.pt = pt_q;
    n = '0;
    pb_d = pb_q; rem_d = rem_q; fl_d = fl_q; hdr_d = hdr_q; frag_d = frag_q;
    ff_d = ff_q; aue_d = aue_q; nro_d = nro_q; ts_d = ts_q;
    size = '0; sum = '0; fits = 1'b0; fl_code = 2'd0; t = '0; pbw = '0;
    do_frag = 1'b0; fl_bad = 1'b0; nr = 1'b0;
    cap = (mtu_q >= 16'd3) ? mtu_q - 16'd2 : 16'd1;
    left = rem_q; fsz = '0; fu = '0;

    if (mode_i) begin
      if (pb_q != 16'd0 || frag_q) begin
        job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: 1'b1, disp: nro_q}; n = n + 3'd1;
      end
      pb_d = '0; rem_d = '0; fl_d = '0; frag_d = 1'b0; ff_d = 1'b0;
    end else if (nal_first_i) begin
      nr = nro_q;
      if (rem_q != '0) begin
        if (frag_q) begin
          job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: 1'b0, disp: nr}; n = n + 3'd1;
        end else if (aue_q && pb_q != 16'd0) begin
          job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: 1'b1, disp: nr}; n = n + 3'd1;
          pb_d = '0;
        end
      end
      frag_d = 1'b0; fl_d = '0;
      size = (nal_size_i == '0) ? SizeBits'(1) : nal_size_i;
      hdr_d = data_byte_i;
      ts_d = timestamp_i;
      job.ts = timestamp_i;
      aue_d = au_end_i;
      sum = WB'(pb_d) + WB'(size);
      if (au_start_i) fl_code = 2'd1;
      else if (sum >= WB'(mtu_q)) fl_code = 2'd2;
      else if (!agg_q) fl_code = 2'd2;
      fl_bad = fl_code != 2'd0;
      if (pb_d != 16'd0 && fl_bad) begin
        job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: fl_code == 2'd1, disp: nr};
        n = n + 3'd1;
        pb_d = '0;
      end
      if (pb_d == 16'd0) begin
        job.evt[n] = '{kind: KindStart, byte_val: 8'd0, flag: 1'b0, disp: 1'b0}; n = n + 3'd1;
        nr = 1'b1;
      end
      t = data_byte_i[4:0];
      if (!(t == 5'd1 || t == 5'd9 || t == 5'd10 || t == 5'd11 || t == 5'd12)) nr = 1'b0;
      nro_d = nr;
      sum = WB'(pb_d) + WB'(size);
      fits = sum < WB'(mtu_q);
      rem_d = size - SizeBits'(1);
      if (fits) begin
        pbw = WB'(pb_d);
        if (!(au_end_i && pb_d == 16'd0)) begin
          if (pb_d == 16'd0) begin
            job.evt[n] = '{kind: KindByte, byte_val: (data_byte_i & NriMask) | StapType,
                           flag: 1'b0, disp: 1'b0};
            n = n + 3'd1;
            pbw = WB'(1);
          end
          job.evt[n] = '{kind: KindByte, byte_val: 8'((size >> 8) & SizeBits'(8'hFF)),
                         flag: 1'b0, disp: 1'b0};
          n = n + 3'd1;
          job.evt[n] = '{kind: KindByte, byte_val: size[7:0], flag: 1'b0, disp: 1'b0};
          n = n + 3'd1;
          pbw = pbw + WB'(2);
        end
        job.evt[n] = '{kind: KindByte, byte_val: data_byte_i, flag: 1'b0, disp: 1'b0};
        n = n + 3'd1;
        pbw = pbw + WB'(size);
        pb_d = (pbw > WB'(16'hFFFF)) ? 16'hFFFF : pbw[15:0];
        if (rem_d == '0 && au_end_i) begin
          job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: 1'b1, disp: nr}; n = n + 3'd1;
          pb_d = '0;
        end
      end else begin
        frag_d = 1'b1;
        ff_d = 1'b1;
        if (rem_d == '0) begin
          job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: au_end_i, disp: nr}; n = n + 3'd1;
          frag_d = 1'b0;
        end else begin
          do_frag = 1'b1;
          left = rem_d;
        end
      end
    end else if (rem_q != '0) begin
      job.evt[n] = '{kind: KindByte, byte_val: data_byte_i, flag: 1'b0, disp: 1'b0};
      n = n + 3'd1;
      rem_d = rem_q - SizeBits'(1);
      if (frag_q) begin
        if (fl_q != 16'd0) fl_d = fl_q - 16'd1;
        if (rem_d == '0) begin
          job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: aue_q, disp: nro_q};
          n = n + 3'd1;
          frag_d = 1'b0; fl_d = '0;
        end else if (fl_d == 16'd0) begin
          job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: 1'b0, disp: nro_q};
          n = n + 3'd1;
          job.evt[n] = '{kind: KindStart, byte_val: 8'd0, flag: 1'b0, disp: 1'b0};
          n = n + 3'd1;
          do_frag = 1'b1;
          left = rem_d;
        end
      end else if (rem_d == '0 && aue_q) begin
        job.evt[n] = '{kind: KindEnd, byte_val: 8'd0, flag: 1'b1, disp: nro_q}; n = n + 3'd1;
        pb_d = '0;
      end
    end

    if (do_frag) begin
      fsz = ((WB'(left) + WB'(2)) > WB'(mtu_q)) ? cap : left[15:0];
      fu = hdr_d & TypeMask;
      if (ff_d) fu = fu | FuStart;
      else if (WB'(fsz) == WB'(left)) fu = fu | FuEnd;
      job.evt[n] = '{kind: KindByte, byte_val: (hdr_d & NriMask) | FuType,
                     flag: 1'b0, disp: 1'b0};
      n = n + 3'd1;
      job.evt[n] = '{kind: KindByte, byte_val: fu, flag: 1'b0, disp: 1'b0};
      n = n + 3'd1;
      fl_d = fsz;
      ff_d = 1'b0;
    end
    job.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q <= '0; rem_q <= '0; fl_q <= '0; hdr_q <= '0; frag_q <= 1'b0;
      ff_q <= 1'b0; aue_q <= 1'b0; nro_q <= 1'b0; ts_q <= '0;
    end else if (fire) begin
      pb_q <= pb_d; rem_q <= rem_d; fl_q <= fl_d; hdr_q <= hdr_d; frag_q <= frag_d;
      ff_q <= ff_d; aue_q <= aue_d; nro_q <= nro_d; ts_q <= ts_d;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> job.count <= 3'(MaxEvents))
    else $error("job event count exceeds limit");
  a_frag_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frag_q |-> rem_q != '0)
    else $error("fragmenting without unit bytes left");
  a_stap_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !mode_i && !nal_first_i && rem_q == '0 |-> job.count == 3'd0)
    else $error("stray byte produced output");

endmodule

/* design/hrp_queue.sv */
// Short FIFO of jobs between the front and back ends.
module hrp_queue import hrp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (AW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + (AW+1)'(1))
    else $error("queue count did not advance");
  a_cnt_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd && !wr |=> cnt_q == $past(cnt_q) - (AW+1)'(1))
    else $error("queue count did not drop");

endmodule

/* design/hrp_back.sv */
// Back end: plays each job out word by word, numbering packet starts.
module hrp_back import hrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic [2:0]  idx_q, idx_d;
  logic [15:0] seq_q, seq_d;
  logic        ov_q;
  res_t        ob_q;
  logic        load, issue;
  evt_t        e;
  res_t        r;

  assign out_valid_o = ov_q;
  assign out_o       = ob_q;
  assign load        = !ov_q || out_ready_i;
  // Empty jobs retire without a word.
  assign issue       = job_valid_i && load && job_i.count != 3'd0;
  assign e           = job_i.evt[idx_q];

  always_comb begin
    r = '0;
    seq_d = seq_q;
    r.kind = e.kind;
    case (e.kind)
      KindByte:  r.payload_byte = e.byte_val;
      KindStart: begin
        seq_d = seq_q + 16'd1;
        r.sequence_res = seq_d;
        r.timestamp_out = job_i.ts;
        r.payload_type_out = job_i.pt;
      end
      KindEnd: begin
        r.marker = e.flag;
        r.disposable = e.disp;
      end
      default: ;
    endcase
    r.last = (idx_q + 3'd1) == job_i.count;
    idx_d = r.last ? 3'd0 : idx_q + 3'd1;
  end

  assign job_ready_o = job_valid_i && load && (job_i.count == 3'd0 || r.last);

  always_ff @(posedge clk_i) begin
    if (issue) ob_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; seq_q <= '0; ov_q <= 1'b0;
    end else begin
      if (load) ov_q <= issue;
      if (issue) begin
        idx_q <= idx_d;
        seq_q <= seq_d;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < job_i.count || job_i.count == 3'd0)
    else $error("event index past job end");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && e.kind == KindStart |=> seq_q == $past(seq_q) + 16'd1)
    else $error("sequence number did not advance");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ob_q))
    else $error("output word changed while stalled");

endmodule

/* design/h264_rtp_payload_packetizer_top.sv */
// H.264 RTP payload packetizer: STAP-A aggregation, single NAL and FU-A split.
//
// Channels: in_if carries one NAL byte (or a flush) per word; out_if carries
// one result word (payload byte, packet start or packet end), with last set
// on the final word caused by an input word. cfg_if writes mtu (index 0),
// aggregate_enable (1) and payload_type (2); write only while idle.
// The front end decodes each input word combinationally into a job of up to
// six events and updates the packing state; a four-entry job queue decouples
// it from the back end, which emits one word per cycle from a registered
// output while out_if is ready. A result passes the queue, then the output
// register. Throughput: one input word per cycle while each yields at most one
// result, out_if ready; a header burst holds the back end, the queue absorbs it.
// Reset clears all state and loads mtu 1400, aggregation on, payload type 96.
// When the receiver stalls, the output word holds, the queue fills and then
// in_if.ready drops; nothing is lost.
module h264_rtp_payload_packetizer_top import hrp_pkg::*; #(
  parameter int unsigned SizeBits = SizeBitsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  hrp_stream_if.sink   cfg_if,
  hrp_stream_if.sink   in_if,
  hrp_stream_if.source out_if
);

  job_t fj, qj;
  logic fv, fr, qv, qr;

  assign cfg_if.ready = 1'b1;

  hrp_front #(.SizeBits(SizeBits)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i (cfg_if.valid),
    .cfg_index_i (cfg_if.data.index),
    .cfg_data_i  (32'(cfg_if.data.value)),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .mode_i      (in_if.data.mode),
    .data_byte_i (in_if.data.data_byte),
    .nal_first_i (in_if.data.nal_first),
    .nal_size_i  (in_if.data.nal_size[SizeBits-1:0]),
    .au_end_i    (in_if.data.au_end),
    .au_start_i  (in_if.data.au_start),
    .timestamp_i (in_if.data.timestamp_in),
    .job_valid_o (fv),
    .job_ready_i (fr),
    .job_o       (fj)
  );

  hrp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (fv), .wr_ready_o (fr), .wr_data_i (fj),
    .rd_valid_o (qv), .rd_ready_i (qr), .rd_data_o (qj)
  );

  hrp_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (qv), .job_ready_o (qr), .job_i (qj),
    .out_valid_o (out_if.valid), .out_ready_i (out_if.ready), .out_o (out_if.data)
  );

endmodule

/* test/hrp_tb_pkg.sv */
// Word layouts of the input and register-write channels used by the packetizer bench.
package hrp_tb_pkg;

  localparam int unsigned TbSizeBits = 24;

  typedef struct packed {
    logic                  mode;
    logic [7:0]            data_byte;
    logic                  nal_first;
    logic [TbSizeBits-1:0] nal_size;
    logic                  au_end;
    logic                  au_start;
    logic [31:0]           timestamp_in;
  } nal_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } cfg_word_t;

  localparam logic ModeByte  = 1'b0;
  localparam logic ModeFlush = 1'b1;

endpackage

/* test/hrp_packet_checker.sv */
// Packet predictor and result comparator watching the packetizer channels.
module hrp_packet_checker import hrp_pkg::*; import hrp_tb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  hrp_stream_if cfg_mon,
  hrp_stream_if in_mon,
  hrp_stream_if out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  logic [15:0] mtu_q;
  logic        agg_q;
  logic [6:0]  pt_q;
  int unsigned pkt_bytes;
  logic [15:0] seq_q;
  int unsigned nal_left;
  int unsigned frag_left;
  logic [7:0]  nal_hdr;
  logic        fragmenting;
  logic        first_frag;
  logic        aue_latched;
  logic        non_ref;
  logic [31:0] cur_ts;
  int          step_words;

  res_t expected_words[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_words.size();

  function automatic void put(logic [1:0] k, logic [7:0] b, logic m, logic [15:0] s,
                              logic [31:0] ts, logic [6:0] p, logic d);
    res_t r;
    if (step_words >= MaxEvents) return;
    r.kind = k; r.payload_byte = b; r.marker = m; r.sequence_res = s;
    r.timestamp_out = ts; r.payload_type_out = p; r.disposable = d; r.last = 1'b0;
    expected_words.push_back(r);
    step_words++;
  endfunction

  function automatic void open_packet();
    seq_q = seq_q + 16'd1;
    put(KindStart, 8'd0, 1'b0, seq_q, cur_ts, pt_q, 1'b0);
  endfunction

  function automatic void close_packet(logic m);
    put(KindEnd, 8'd0, m, 16'd0, 32'd0, 7'd0, non_ref);
  endfunction

  function automatic void open_fragment();
    int unsigned cap;
    int unsigned sz;
    logic [7:0]  fu;
    cap = (mtu_q >= 3) ? mtu_q - 2 : 1;
    sz  = (longint'(nal_left) + 2 > longint'(mtu_q)) ? cap : nal_left;
    fu  = nal_hdr & TypeMask;
    if (first_frag) fu = fu | FuStart;
    else if (sz == nal_left) fu = fu | FuEnd;
    put(KindByte, (nal_hdr & NriMask) | FuType, 1'b0, 16'd0, 32'd0, 7'd0, 1'b0);
    put(KindByte, fu, 1'b0, 16'd0, 32'd0, 7'd0, 1'b0);
    frag_left  = sz;
    first_frag = 1'b0;
  endfunction

  function automatic void predict_word(nal_word_t w);
    longint unsigned sz;
    int          fl;
    logic [4:0]  t;
    int          prev_size;
    prev_size = expected_words.size();
    step_words = 0;
    if (w.mode == ModeFlush) begin
      if (pkt_bytes != 0 || fragmenting) close_packet(1'b1);
      pkt_bytes = 0; nal_left = 0; frag_left = 0; fragmenting = 0; first_frag = 0;
    end else if (w.nal_first) begin
      sz = w.nal_size;
      fl = 0;
      // abandon a unit still in progress
      if (nal_left != 0) begin
        if (fragmenting) close_packet(1'b0);
        else if (aue_latched && pkt_bytes != 0) begin
          close_packet(1'b1); pkt_bytes = 0;
        end
        nal_left = 0; fragmenting = 0; frag_left = 0;
      end
      if (sz == 0) sz = 1;
      nal_hdr = w.data_byte;
      cur_ts = w.timestamp_in;
      aue_latched = w.au_end;
      if (w.au_start) fl = 1;
      else if (pkt_bytes + sz >= mtu_q) fl = 2;
      else if (!agg_q) fl = 2;
      if (pkt_bytes != 0 && fl != 0) begin
        close_packet(fl == 1); pkt_bytes = 0;
      end
      if (pkt_bytes == 0) begin
        open_packet(); non_ref = 1'b1;
      end
      t = w.data_byte[4:0];
      if (!(t == 1 || t == 9 || t == 10 || t == 11 || t == 12)) non_ref = 1'b0;
      if (pkt_bytes + sz < mtu_q) begin
        if (!(w.au_end && pkt_bytes == 0)) begin
          if (pkt_bytes == 0) begin
            put(KindByte, (w.data_byte & NriMask) | StapType, 0, 0, 0, 0, 0);
            pkt_bytes = 1;
          end
          put(KindByte, sz[15:8], 0, 0, 0, 0, 0);
          put(KindByte, sz[7:0], 0, 0, 0, 0, 0);
          pkt_bytes += 2;
        end
        put(KindByte, w.data_byte, 0, 0, 0, 0, 0);
        pkt_bytes = (pkt_bytes + sz > 65535) ? 65535 : pkt_bytes + sz;
        fragmenting = 0;
        nal_left = sz - 1;
        if (nal_left == 0 && w.au_end) begin
          close_packet(1'b1); pkt_bytes = 0;
        end
      end else begin
        fragmenting = 1; first_frag = 1;
        nal_left = sz - 1;
        if (nal_left == 0) begin
          close_packet(w.au_end); fragmenting = 0;
        end else open_fragment();
      end
    end else if (nal_left != 0) begin
      put(KindByte, w.data_byte, 0, 0, 0, 0, 0);
      nal_left--;
      if (fragmenting) begin
        if (frag_left != 0) frag_left--;
        if (nal_left == 0) begin
          close_packet(aue_latched); fragmenting = 0; frag_left = 0;
        end else if (frag_left == 0) begin
          close_packet(1'b0); open_packet(); open_fragment();
        end
      end else if (nal_left == 0 && aue_latched) begin
        close_packet(1'b1); pkt_bytes = 0;
      end
    end
    if (expected_words.size() > prev_size) expected_words[$].last = 1'b1;
  endfunction

  task automatic compare_word(res_t got);
    res_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected result word %h", got);
      fails++;
      return;
    end
    want = expected_words.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind); fails++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
      fails++;
    end
    if (got.marker !== want.marker) begin
      $error("marker: expected %0d, got %0d", want.marker, got.marker); fails++;
    end
    if (got.sequence_res !== want.sequence_res) begin
      $error("sequence_res: expected %0d, got %0d", want.sequence_res, got.sequence_res);
      fails++;
    end
    if (got.timestamp_out !== want.timestamp_out) begin
      $error("timestamp_out: expected %0h, got %0h", want.timestamp_out, got.timestamp_out);
      fails++;
    end
    if (got.payload_type_out !== want.payload_type_out) begin
      $error("payload_type_out: expected %0d, got %0d", want.payload_type_out,
             got.payload_type_out);
      fails++;
    end
    if (got.disposable !== want.disposable) begin
      $error("disposable: expected %0d, got %0d", want.disposable, got.disposable); fails++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last); fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q = MtuReset; agg_q = 1'b1; pt_q = PtReset;
      pkt_bytes = 0; seq_q = 0; nal_left = 0; frag_left = 0; nal_hdr = 0;
      fragmenting = 0; first_frag = 0; aue_latched = 0; non_ref = 0; cur_ts = 0;
      expected_words.delete();
      fails = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.index)
          CfgMtu: mtu_q = cfg_mon.data.value;
          CfgAgg: agg_q = cfg_mon.data.value[0];
          CfgPt:  pt_q  = cfg_mon.data.value[6:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_word(in_mon.data);
      if (out_mon.valid && out_mon.ready) compare_word(out_mon.data);
    end
  end

endmodule

/* test/h264_rtp_payload_packetizer_top_tb.sv */
// Stimulus and verdict for the H.264 RTP payload packetizer.
module h264_rtp_payload_packetizer_top_tb import hrp_pkg::*; import hrp_tb_pkg::*;;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  logic idle_on = 1'b1;
  int   out_hold;
  int   sent;

  hrp_stream_if #(.T(cfg_word_t)) cfg_ch ();
  hrp_stream_if #(.T(nal_word_t)) in_ch ();
  hrp_stream_if #(.T(res_t))      out_ch ();

  h264_rtp_payload_packetizer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  hrp_packet_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: hold off at random after each word while idle_on is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        out_hold = idle_on ? $urandom_range(0, 10) : 0;
        if (out_hold > 0) out_ch.ready <= 1'b0;
      end else if (!out_ch.ready) begin
        if (out_hold <= 1) out_ch.ready <= 1'b1;
        else out_hold--;
      end
    end
  end

  task automatic send_word(nal_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_ctrl(logic flush, logic [7:0] b);
    nal_word_t w;
    w = '0;
    w.mode = flush;
    w.data_byte = b;
    send_word(w);
  endtask

  // send a unit header and count further bytes
  task automatic send_unit(logic [7:0] hdr, logic [23:0] sz, int n_bytes, logic aue,
                           logic aus, logic [31:0] ts);
    nal_word_t w;
    w.mode = ModeByte; w.data_byte = hdr; w.nal_first = 1'b1; w.nal_size = sz;
    w.au_end = aue; w.au_start = aus; w.timestamp_in = ts;
    send_word(w);
    for (int i = 1; i < n_bytes; i++) begin
      w = '0;
      w.data_byte = 8'($urandom);
      w.mode = ModeByte;
      w.nal_first = 1'b0;
      send_word(w);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_ch.data  <= '{index: idx, value: v};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    int target;
    int pick;
    int sz;
    target = sent + n_items;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) send_ctrl(ModeFlush, 8'($urandom));
      else if (pick < 8) send_ctrl(ModeByte, 8'($urandom));
      else if (pick < 12) begin
        // huge unit, cut short by the next header
        send_unit(8'($urandom), 24'($urandom), $urandom_range(1, 4), 1'($urandom),
                  1'($urandom), $urandom);
      end else begin
        sz = $urandom_range(0, 40);
        send_unit(8'($urandom), 24'(sz), (sz == 0) ? 1 : sz,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, $urandom);
      end
    end
  endtask

  initial begin
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, empty flush, stray byte, extremes, cut-short units
    send_ctrl(ModeFlush, 8'h00);
    send_ctrl(ModeByte, 8'hFF);
    send_unit(8'hFF, 24'd0, 1, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_unit(8'h01, 24'd3, 3, 1'b0, 1'b0, 32'h0);
    send_unit(8'h09, 24'd2, 2, 1'b1, 1'b0, 32'h1234);
    send_unit(8'h65, 24'd4, 4, 1'b0, 1'b0, 32'h55);
    send_unit(8'h41, 24'd2, 2, 1'b0, 1'b1, 32'h66);
    send_unit(8'h05, 24'hFF_FFFF, 3, 1'b1, 1'b0, 32'h77);
    send_unit(8'h0C, 24'd5, 2, 1'b1, 1'b0, 32'h88);
    send_unit(8'h00, 24'd3, 1, 1'b0, 1'b0, 32'h99);
    send_ctrl(ModeFlush, 8'h00);
    drain();

    write_reg(CfgMtu, 16'd16);
    write_reg(CfgAgg, 16'd0);
    write_reg(CfgPt, 16'd127);
    send_unit(8'h7C, 24'd16, 16, 1'b1, 1'b0, 32'hA5A5_5A5A);
    send_unit(8'h1F, 24'd1, 1, 1'b0, 1'b0, 32'h1);
    random_phase(30);
    drain();

    write_reg(CfgMtu, 16'd65535);
    write_reg(CfgAgg, 16'd1);
    write_reg(CfgPt, 16'd0);
    idle_on = 1'b0;
    random_phase(25);
    drain();

    idle_on = 1'b1;
    write_reg(CfgMtu, 16'($urandom_range(17, 60)));
    write_reg(CfgPt, 16'($urandom_range(0, 127)));
    random_phase(30);
    drain();

    write_reg(CfgMtu, 16'd1400);
    write_reg(CfgPt, 16'd96);
    random_phase(25);
    send_ctrl(ModeFlush, 8'h00);
    drain();

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
